### hdl/lpg_pkg.sv
package lpg_pkg;

   localparam int DUTY_BITS = 8;
   localparam int COS_DEPTH_DEF = 256;

   localparam logic [16:0] DUTY_MAX = 17'((1 << DUTY_BITS) - 1);

   // divider widths: dividend covers the triangle numerator and the Q0.16 fraction
   localparam int DVD_W = (DUTY_BITS + 19 > 32) ? DUTY_BITS + 19 : 32;
   localparam int DVS_W = 17;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEPS = 3'd5;

   localparam logic [2:0] MODE_CONST = 3'd0;
   localparam logic [2:0] MODE_BLINK = 3'd1;
   localparam logic [2:0] MODE_TRIANGLE = 3'd2;
   localparam logic [2:0] MODE_BREATHE = 3'd3;
   localparam logic [2:0] MODE_THROB = 3'd4;
   localparam logic [2:0] MODE_STEP = 3'd5;

   typedef struct packed {
      logic [7:0] ms_step;
      logic restart;
   } req_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] duty;
      logic wrapped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_SHAPE,
      ST_MUL_A,
      ST_LAUNCH_A,
      ST_DIV_F,
      ST_MUL_I,
      ST_ROM,
      ST_MUL_R,
      ST_ROUND,
      ST_DIV_L,
      ST_MUL_B,
      ST_LAUNCH_B,
      ST_DIV_B,
      ST_DONE
   } state_type;

endpackage

### hdl/lpg_div.sv
module lpg_div (
   input logic clock,
   input logic reset,
   input logic start,
   input logic [lpg_pkg::DVD_W-1:0] dividend,
   input logic [lpg_pkg::DVS_W-1:0] divisor,
   output logic done,
   output logic [lpg_pkg::DVD_W-1:0] quotient,
   output logic [lpg_pkg::DVS_W-1:0] remainder
);
   import lpg_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic busy_ff;
   logic done_ff;

   logic [DVS_W:0] shifted;
   logic [DVS_W:0] diff;
   logic fits;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      diff = shifted - {1'b0, dvs_ff};
      fits = shifted >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            quo_ff <= dividend;
            rem_ff <= '0;
            dvs_ff <= divisor;
            cnt_ff <= CNT_W'(DVD_W);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            quo_ff <= {quo_ff[DVD_W-2:0], fits};
            rem_ff <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;

endmodule

### hdl/led_pattern_generator.sv
// channel   | valid     | stall     | payload
// request   | req_valid | req_stall | req_data (ms_step, restart)
// result    | rsp_valid | rsp_stall | rsp_data (duty, wrapped)
// csr write | csr_we    | -         | csr_index, csr_wdata
//
// One request at a time. Constant mode goes straight to DONE; blink makes one
// pass through the shared restoring divider, breathe/throb and triangle two, step three.
// Synchronous reset, no clearing pass. A new request is taken while a result
// waits in the output register; a stalled result holds the next one in DONE.
module led_pattern_generator #(
   parameter int COS_TABLE_DEPTH = lpg_pkg::COS_DEPTH_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input lpg_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output lpg_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic [lpg_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [lpg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lpg_pkg::*;

   localparam int IDX_W = $clog2(COS_TABLE_DEPTH);

   // raised cosine entry, Q16, from an 8-term Taylor cosine folded to [0, pi/2]
   function automatic logic [16:0] rc_entry(input int unsigned i);
      longint unsigned k;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned num;
      longint sm;
      bit neg;
      k = i;
      neg = 1'b0;
      if (k > COS_TABLE_DEPTH / 2) k = COS_TABLE_DEPTH - k;
      if (4 * k > COS_TABLE_DEPTH) begin
         k = COS_TABLE_DEPTH / 2 - k;
         neg = 1'b1;
      end
      x = (k * 64'd6746518852) / COS_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = 64'd1073741824;
      sm = 64'sd1073741824;
      // series divisors (2n-1)*2n for n = 1..7
      term = ((term * x2) >> 30) >> 1;
      sm = sm - longint'(term);
      term = ((term * x2) >> 30) / 64'd12;
      sm = sm + longint'(term);
      term = ((term * x2) >> 30) / 64'd30;
      sm = sm - longint'(term);
      term = ((term * x2) >> 30) / 64'd56;
      sm = sm + longint'(term);
      term = ((term * x2) >> 30) / 64'd90;
      sm = sm - longint'(term);
      term = ((term * x2) >> 30) / 64'd132;
      sm = sm + longint'(term);
      term = ((term * x2) >> 30) / 64'd182;
      sm = sm - longint'(term);
      if (sm > 64'sd1073741824) sm = 64'sd1073741824;
      if (sm < 0) sm = 0;
      num = neg ? longint'(64'sd1073741824 + sm) : longint'(64'sd1073741824 - sm);
      return 17'((num + 64'd16384) >> 15);
   endfunction

   logic [16:0] rc_rom [COS_TABLE_DEPTH];
   for (genvar g = 0; g < COS_TABLE_DEPTH; g++) begin : g_rom
      assign rc_rom[g] = rc_entry(g);
   end

   state_type state_ff, state_in;

   logic [2:0] mode_ff;
   logic [7:0] const_ff;
   logic [15:0] period_ff;
   logic [15:0] attack_ff;
   logic [15:0] decay_ff;
   logic [7:0] steps_ff;
   logic [16:0] phase_ff;

   logic [16:0] d_ff;
   logic wrap_ff;
   logic hi_ff;
   logic [15:0] f_ff;
   logic [16:0] rc_ff;
   logic [7:0] level_ff;
   logic [33:0] prod_ff;
   logic [DUTY_BITS-1:0] duty_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   logic accept;
   logic is_const;
   logic [16:0] p_eff;
   logic [16:0] a_eff;
   logic [16:0] dc_eff;
   logic [7:0] n_eff;
   logic [7:0] nm1;
   logic [17:0] s_sum;
   logic [16:0] len;
   logic [16:0] tri_x;
   logic out_free;

   logic div_start;
   logic [DVD_W-1:0] div_dvd;
   logic [DVS_W-1:0] div_dvs;
   logic div_done;
   logic [DVD_W-1:0] div_quo;
   logic [DVS_W-1:0] div_rem;
   logic [16:0] mul_a;
   logic [16:0] mul_b;

   lpg_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .dividend(div_dvd),
      .divisor(div_dvs),
      .done(div_done),
      .quotient(div_quo),
      .remainder(div_rem)
   );

   always_comb begin
      accept = req_valid && !req_stall;
      is_const = (mode_ff < MODE_BLINK) || (mode_ff > MODE_STEP);
      p_eff = (period_ff == 16'd0) ? 17'd1 : {1'b0, period_ff};
      a_eff = (attack_ff == 16'd0) ? 17'd1 : {1'b0, attack_ff};
      dc_eff = (decay_ff == 16'd0) ? 17'd1 : {1'b0, decay_ff};
      n_eff = (steps_ff < 8'd2) ? 8'd2 : steps_ff;
      nm1 = n_eff - 8'd1;
      s_sum = (req_data.restart ? 18'd0 : {1'b0, phase_ff}) + 18'(req_data.ms_step);
      case (mode_ff)
         MODE_BLINK: len = {p_eff[15:0], 1'b0};
         MODE_THROB: len = a_eff + dc_eff;
         default: len = p_eff;
      endcase
      // triangle folds the falling half onto the rising one
      tri_x = ({1'b0, d_ff} << 1) < {1'b0, p_eff} ? d_ff : p_eff - d_ff;
      out_free = !(rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = is_const ? ST_DONE : ST_MOD;
         ST_MOD: if (div_done) state_in = ST_SHAPE;
         ST_SHAPE: begin
            case (mode_ff) inside
               MODE_BLINK: state_in = ST_DONE;
               MODE_BREATHE, MODE_THROB: state_in = ST_DIV_F;
               default: state_in = ST_MUL_A;
            endcase
         end
         ST_MUL_A: state_in = ST_LAUNCH_A;
         ST_LAUNCH_A: state_in = (mode_ff == MODE_STEP) ? ST_DIV_L : ST_DIV_B;
         ST_DIV_F: if (div_done) state_in = ST_MUL_I;
         ST_MUL_I: state_in = ST_ROM;
         ST_ROM: state_in = ST_MUL_R;
         ST_MUL_R: state_in = ST_ROUND;
         ST_ROUND: state_in = ST_DONE;
         ST_DIV_L: if (div_done) state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_LAUNCH_B;
         ST_LAUNCH_B: state_in = ST_DIV_B;
         ST_DIV_B: if (div_done) state_in = ST_DONE;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      div_start = 1'b0;
      div_dvd = DVD_W'(s_sum);
      div_dvs = len;
      mul_a = DUTY_MAX;
      mul_b = tri_x;
      unique case (state_ff)
         ST_IDLE: div_start = accept && !is_const;
         ST_SHAPE: begin
            if (mode_ff == MODE_BREATHE) begin
               div_start = 1'b1;
               div_dvd = DVD_W'(d_ff) << 16;
               div_dvs = p_eff;
            end else if (mode_ff == MODE_THROB) begin
               div_start = 1'b1;
               if (d_ff < a_eff) begin
                  div_dvd = DVD_W'(d_ff) << 15;
                  div_dvs = a_eff;
               end else begin
                  div_dvd = DVD_W'(d_ff - a_eff) << 15;
                  div_dvs = dc_eff;
               end
            end
         end
         ST_MUL_A: begin
            if (mode_ff == MODE_STEP) begin
               mul_a = d_ff;
               mul_b = 17'(n_eff);
            end
         end
         ST_LAUNCH_A: begin
            div_start = 1'b1;
            if (mode_ff == MODE_STEP) begin
               div_dvd = DVD_W'(prod_ff);
               div_dvs = p_eff;
            end else begin
               div_dvd = (DVD_W'(prod_ff) << 2) + DVD_W'(p_eff);
               div_dvs = p_eff << 1;
            end
         end
         ST_MUL_I: begin
            mul_a = {1'b0, f_ff};
            mul_b = 17'(COS_TABLE_DEPTH);
         end
         ST_MUL_R: mul_b = rc_ff;
         ST_MUL_B: mul_b = 17'(level_ff);
         ST_LAUNCH_B: begin
            div_start = 1'b1;
            div_dvd = (DVD_W'(prod_ff) << 1) + DVD_W'(nm1);
            div_dvs = 17'(nm1) << 1;
         end
         default: div_start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= MODE_CONST;
         const_ff <= 8'd0;
         period_ff <= 16'd1000;
         attack_ff <= 16'd500;
         decay_ff <= 16'd500;
         steps_ff <= 8'd4;
         phase_ff <= 17'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MODE: mode_ff <= csr_wdata[2:0];
               CSR_CONST: const_ff <= csr_wdata[7:0];
               CSR_PERIOD: period_ff <= csr_wdata;
               CSR_ATTACK: attack_ff <= csr_wdata;
               CSR_DECAY: decay_ff <= csr_wdata;
               CSR_STEPS: steps_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (is_const) begin
                     duty_ff <= DUTY_BITS'(const_ff);
                     wrap_ff <= 1'b0;
                     phase_ff <= 17'd0;
                  end else begin
                     wrap_ff <= s_sum >= {1'b0, len};
                  end
               end
            end
            ST_MOD: begin
               if (div_done) begin
                  d_ff <= div_rem;
                  phase_ff <= div_rem;
               end
            end
            ST_SHAPE: begin
               duty_ff <= (d_ff < p_eff) ? DUTY_MAX[DUTY_BITS-1:0] : '0;
               hi_ff <= (mode_ff == MODE_THROB) && (d_ff >= a_eff);
            end
            ST_MUL_A, ST_MUL_I, ST_MUL_R, ST_MUL_B: prod_ff <= mul_a * mul_b;
            ST_DIV_F: if (div_done) f_ff <= div_quo[15:0] | {hi_ff, 15'd0};
            ST_ROM: rc_ff <= rc_rom[prod_ff[16 +: IDX_W]];
            ST_ROUND: duty_ff <= DUTY_BITS'((prod_ff + 34'd32768) >> 16);
            ST_DIV_L: begin
               if (div_done)
                  level_ff <= (div_quo > DVD_W'(nm1)) ? nm1 : div_quo[7:0];
            end
            ST_DIV_B: if (div_done) duty_ff <= div_quo[DUTY_BITS-1:0];
            ST_DONE: begin
               if (out_free) begin
                  rsp_ff.duty <= duty_ff;
                  rsp_ff.wrapped <= wrap_ff;
                  rsp_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

### hdl/lpg_checker.sv
module lpg_props (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input lpg_pkg::rsp_type rsp_data
);

   // a taken request keeps the block busy for at least the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken but block not busy");

   // a new result only appears after the block was working
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result dropped or changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("block not idle after reset");

endmodule

bind led_pattern_generator lpg_props u_lpg_props (.*);
